[rtl/core/lsc_pkg.sv]
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared widths, codes and the segment record for the window clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

    localparam int COORD_BITS  = 20;
    localparam int T_FRAC_BITS = 16;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int REM_BITS    = DIFF_BITS + 1;
    localparam int Q_BITS      = T_FRAC_BITS + 1;
    localparam int PROD_BITS   = Q_BITS + DIFF_BITS;
    localparam int N_LANES     = 4;
    localparam int SMALL_SCALE = 100000;
    localparam int SMALL_BITS  = 17;
    localparam int SMALL_PBITS = DIFF_BITS + SMALL_BITS;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 2'd3;

    localparam int LANE_LEFT   = 0;
    localparam int LANE_TOP    = 1;
    localparam int LANE_RIGHT  = 2;
    localparam int LANE_BOTTOM = 3;

    localparam logic [3:0] OC_RIGHT = 4'b0001;
    localparam logic [3:0] OC_BELOW = 4'b0010;
    localparam logic [3:0] OC_ABOVE = 4'b0100;
    localparam logic [3:0] OC_LEFT  = 4'b1000;

    localparam logic [Q_BITS-1:0] T_ONE = Q_BITS'(1) << T_FRAC_BITS;
    localparam logic [Q_BITS-1:0] T_SAT = {Q_BITS{1'b1}};
    localparam logic [PROD_BITS-1:0] T_HALF = PROD_BITS'(1) << (T_FRAC_BITS - 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic [DIFF_BITS-1:0]         t_mag;
    typedef logic [REM_BITS-1:0]          t_rem;
    typedef logic [Q_BITS-1:0]            t_quo;

    typedef struct packed {
        t_coord               x1;
        t_coord               y1;
        t_coord               x2;
        t_coord               y2;
        t_diff                dx;
        t_diff                dy;
        logic                 all_in;
        logic                 reject;
        logic [N_LANES-1:0]   skip;
        logic [N_LANES-1:0]   small_t;
        logic [N_LANES-1:0]   opp;
        logic [N_LANES-1:0]   dneg;
        logic [N_LANES-1:0]   sat;
        t_mag [N_LANES-1:0]   ad;
        t_rem [N_LANES-1:0]   rem;
        t_quo [N_LANES-1:0]   quo;
    } t_seg;

endpackage

`default_nettype wire

[rtl/core/line_segment_window_clipper.sv]
// ----------------------------------------------------------------------------
// line_segment_window_clipper
// Clips one line segment per beat to the configured window.
// ----------------------------------------------------------------------------
//  channel | signals                                 | beat
//  in      | i_in_valid / o_in_ready                 | start_x/y, end_x/y
//  out     | o_out_valid / i_out_ready               | visible, clipped points
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data       | one window register
//
//  One segment per cycle while the output beat is not stalled.
//  The row of 17 divider cells resolves t, one bit each.
//  All stages advance together; a stalled output beat holds the whole row.
//  Synchronous active-low reset clears all valid flags and loads the
//  default window.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_window_clipper import lsc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire t_coord                  i_start_x,
    input  wire t_coord                  i_start_y,
    input  wire t_coord                  i_end_x,
    input  wire t_coord                  i_end_y,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_visible,
    output t_coord                       o_clipped_start_x,
    output t_coord                       o_clipped_start_y,
    output t_coord                       o_clipped_end_x,
    output t_coord                       o_clipped_end_y,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire t_coord                  i_cfg_data
);

    t_coord r_left, r_bottom, r_right, r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_bottom <= '0;
            r_right  <= {1'b0, {(COORD_BITS-1){1'b1}}};
            r_top    <= {1'b0, {(COORD_BITS-1){1'b1}}};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                default:    r_left   <= r_left;
            endcase
        end
    end

    logic adv;
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    logic [Q_BITS:0] v_chain;
    t_seg [Q_BITS:0] s_chain;

    lsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (i_in_valid),
        .i_x1     (i_start_x),
        .i_y1     (i_start_y),
        .i_x2     (i_end_x),
        .i_y2     (i_end_y),
        .i_left   (r_left),
        .i_bottom (r_bottom),
        .i_right  (r_right),
        .i_top    (r_top),
        .o_valid  (v_chain[0]),
        .o_seg    (s_chain[0])
    );

    for (genvar g = 0; g < Q_BITS; g++) begin : g_cell
        lsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (v_chain[g]),
            .i_seg   (s_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_seg   (s_chain[g+1])
        );
    end

    lsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (v_chain[Q_BITS]),
        .i_seg     (s_chain[Q_BITS]),
        .o_valid   (o_out_valid),
        .o_visible (o_visible),
        .o_sx      (o_clipped_start_x),
        .o_sy      (o_clipped_start_y),
        .o_ex      (o_clipped_end_x),
        .o_ey      (o_clipped_end_y)
    );

endmodule

`default_nettype wire

[rtl/core/lsc_front.sv]
// ----------------------------------------------------------------------------
// lsc_front
// Input register, outcodes, border differences and divider seed per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_front import lsc_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire logic   i_valid,
    input  wire t_coord i_x1,
    input  wire t_coord i_y1,
    input  wire t_coord i_x2,
    input  wire t_coord i_y2,
    input  wire t_coord i_left,
    input  wire t_coord i_bottom,
    input  wire t_coord i_right,
    input  wire t_coord i_top,
    output logic        o_valid,
    output t_seg        o_seg
);

    logic   r_v;
    t_coord r_x1, r_y1, r_x2, r_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x1 <= i_x1;
            r_y1 <= i_y1;
            r_x2 <= i_x2;
            r_y2 <= i_y2;
        end
    end

    logic [3:0]                   c1, c2;
    t_diff                        dx, dy;
    t_diff [N_LANES-1:0]          delta, diff;
    t_mag                         af;
    logic [SMALL_PBITS-1:0]       sprod;

    always_comb begin
        c1 = 4'b0;
        c2 = 4'b0;
        if (r_x1 < i_left) c1 = c1 | OC_LEFT;
        else if (r_x1 > i_right) c1 = c1 | OC_RIGHT;
        if (r_y1 < i_bottom) c1 = c1 | OC_BELOW;
        else if (r_y1 > i_top) c1 = c1 | OC_ABOVE;
        if (r_x2 < i_left) c2 = c2 | OC_LEFT;
        else if (r_x2 > i_right) c2 = c2 | OC_RIGHT;
        if (r_y2 < i_bottom) c2 = c2 | OC_BELOW;
        else if (r_y2 > i_top) c2 = c2 | OC_ABOVE;

        dx = t_diff'(r_x2) - t_diff'(r_x1);
        dy = t_diff'(r_y2) - t_diff'(r_y1);
        delta[LANE_LEFT]   = -dx;
        diff[LANE_LEFT]    = t_diff'(r_x1) - t_diff'(i_left);
        delta[LANE_TOP]    = dy;
        diff[LANE_TOP]     = t_diff'(i_top) - t_diff'(r_y1);
        delta[LANE_RIGHT]  = dx;
        diff[LANE_RIGHT]   = t_diff'(i_right) - t_diff'(r_x1);
        delta[LANE_BOTTOM] = -dy;
        diff[LANE_BOTTOM]  = t_diff'(r_y1) - t_diff'(i_bottom);

        o_seg        = '0;
        o_seg.x1     = r_x1;
        o_seg.y1     = r_y1;
        o_seg.x2     = r_x2;
        o_seg.y2     = r_y2;
        o_seg.dx     = dx;
        o_seg.dy     = dy;
        o_seg.all_in = ((c1 | c2) == 4'b0);
        o_seg.reject = ((c1 & c2) != 4'b0);
        o_seg.skip[LANE_LEFT]   = (dx == '0);
        o_seg.skip[LANE_RIGHT]  = (dx == '0);
        o_seg.skip[LANE_TOP]    = (dy == '0);
        o_seg.skip[LANE_BOTTOM] = (dy == '0);
        af    = '0;
        sprod = '0;
        for (int k = 0; k < N_LANES; k++) begin
            af = diff[k][DIFF_BITS-1] ? t_mag'(-diff[k]) : t_mag'(diff[k]);
            o_seg.ad[k] = delta[k][DIFF_BITS-1] ? t_mag'(-delta[k]) : t_mag'(delta[k]);
            sprod = SMALL_PBITS'(af) * SMALL_PBITS'(SMALL_SCALE);
            o_seg.small_t[k] = (sprod < SMALL_PBITS'(o_seg.ad[k]));
            o_seg.dneg[k]    = delta[k][DIFF_BITS-1];
            o_seg.opp[k]     = delta[k][DIFF_BITS-1] != diff[k][DIFF_BITS-1];
            o_seg.sat[k]     = ({1'b0, af} >= {o_seg.ad[k], 1'b0});
            o_seg.rem[k]     = {1'b0, af};
            o_seg.quo[k]     = '0;
        end
    end

    assign o_valid = r_v;

endmodule

`default_nettype wire

[rtl/core/lsc_cell.sv]
// ----------------------------------------------------------------------------
// lsc_cell
// One divider cell: resolves one quotient bit on all four border lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_cell import lsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_valid,
    input  wire t_seg i_seg,
    output logic      o_valid,
    output t_seg      o_seg
);

    logic r_v;
    t_seg r_seg;
    t_seg n_seg;
    t_rem trial;
    logic qbit;

    always_comb begin
        n_seg = i_seg;
        trial = '0;
        qbit  = 1'b0;
        for (int k = 0; k < N_LANES; k++) begin
            qbit  = (i_seg.rem[k] >= {1'b0, i_seg.ad[k]});
            trial = qbit ? (i_seg.rem[k] - {1'b0, i_seg.ad[k]}) : i_seg.rem[k];
            n_seg.rem[k] = {trial[REM_BITS-2:0], 1'b0};
            n_seg.quo[k] = {i_seg.quo[k][Q_BITS-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_seg <= n_seg;
        end
    end

    assign o_valid = r_v;
    assign o_seg   = r_seg;

endmodule

`default_nettype wire

[rtl/core/lsc_back.sv]
// ----------------------------------------------------------------------------
// lsc_back
// Border decisions, parameter products and rounded endpoint output.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_back import lsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_valid,
    input  wire t_seg i_seg,
    output logic      o_valid,
    output logic      o_visible,
    output t_coord    o_sx,
    output t_coord    o_sy,
    output t_coord    o_ex,
    output t_coord    o_ey
);

    // decision stage
    logic  ok;
    t_quo  te, tl, tk;

    always_comb begin
        ok = 1'b1;
        te = '0;
        tl = T_ONE;
        tk = '0;
        for (int k = 0; k < N_LANES; k++) begin
            tk = i_seg.sat[k] ? T_SAT : i_seg.quo[k];
            if (ok && !i_seg.skip[k]) begin
                if (i_seg.small_t[k]) begin
                    ok = 1'b0;
                end else if (i_seg.opp[k]) begin
                    ok = i_seg.dneg[k];
                end else if (i_seg.dneg[k]) begin
                    if (tk > tl) ok = 1'b0;
                    else if (tk > te) te = tk;
                end else begin
                    if (tk < te) ok = 1'b0;
                    else if (tk < tl) tl = tk;
                end
            end
        end
    end

    logic   r_d_v, r_d_vis, r_d_in;
    t_quo   r_d_te, r_d_tl;
    t_coord r_d_x1, r_d_y1, r_d_x2, r_d_y2;
    t_diff  r_d_dx, r_d_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (i_adv) begin
            r_d_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d_vis <= i_seg.all_in | (!i_seg.reject & ok);
            r_d_in  <= i_seg.all_in;
            r_d_te  <= te;
            r_d_tl  <= tl;
            r_d_x1  <= i_seg.x1;
            r_d_y1  <= i_seg.y1;
            r_d_x2  <= i_seg.x2;
            r_d_y2  <= i_seg.y2;
            r_d_dx  <= i_seg.dx;
            r_d_dy  <= i_seg.dy;
        end
    end

    // product stage
    t_mag mdx, mdy;
    assign mdx = r_d_dx[DIFF_BITS-1] ? t_mag'(-r_d_dx) : t_mag'(r_d_dx);
    assign mdy = r_d_dy[DIFF_BITS-1] ? t_mag'(-r_d_dy) : t_mag'(r_d_dy);

    logic                 r_m_v, r_m_vis, r_m_in, r_m_nx, r_m_ny;
    logic [PROD_BITS-1:0] r_m_sx, r_m_sy, r_m_ex, r_m_ey;
    t_coord               r_m_x1, r_m_y1, r_m_x2, r_m_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (i_adv) begin
            r_m_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m_vis <= r_d_vis;
            r_m_in  <= r_d_in;
            r_m_nx  <= r_d_dx[DIFF_BITS-1];
            r_m_ny  <= r_d_dy[DIFF_BITS-1];
            r_m_sx  <= PROD_BITS'(r_d_te) * PROD_BITS'(mdx);
            r_m_sy  <= PROD_BITS'(r_d_te) * PROD_BITS'(mdy);
            r_m_ex  <= PROD_BITS'(r_d_tl) * PROD_BITS'(mdx);
            r_m_ey  <= PROD_BITS'(r_d_tl) * PROD_BITS'(mdy);
            r_m_x1  <= r_d_x1;
            r_m_y1  <= r_d_y1;
            r_m_x2  <= r_d_x2;
            r_m_y2  <= r_d_y2;
        end
    end

    // output stage
    function automatic t_coord f_along(t_coord base, logic neg, logic [PROD_BITS-1:0] p);
        logic [PROD_BITS-1:0] r;
        r = (p + T_HALF) >> T_FRAC_BITS;
        return neg ? t_coord'(base - COORD_BITS'(r)) : t_coord'(base + COORD_BITS'(r));
    endfunction

    logic   r_o_v, r_o_vis;
    t_coord r_o_sx, r_o_sy, r_o_ex, r_o_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_adv) begin
            r_o_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_o_vis <= r_m_vis;
            if (!r_m_vis) begin
                r_o_sx <= '0;
                r_o_sy <= '0;
                r_o_ex <= '0;
                r_o_ey <= '0;
            end else if (r_m_in) begin
                r_o_sx <= r_m_x1;
                r_o_sy <= r_m_y1;
                r_o_ex <= r_m_x2;
                r_o_ey <= r_m_y2;
            end else begin
                r_o_sx <= f_along(r_m_x1, r_m_nx, r_m_sx);
                r_o_sy <= f_along(r_m_y1, r_m_ny, r_m_sy);
                r_o_ex <= f_along(r_m_x1, r_m_nx, r_m_ex);
                r_o_ey <= f_along(r_m_y1, r_m_ny, r_m_ey);
            end
        end
    end

    assign o_valid   = r_o_v;
    assign o_visible = r_o_vis;
    assign o_sx      = r_o_sx;
    assign o_sy      = r_o_sy;
    assign o_ex      = r_o_ex;
    assign o_ey      = r_o_ey;

endmodule

`default_nettype wire

[rtl/core/lsc_checker.sv]
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks on the window clipper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_checker import lsc_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_in_ready,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic                    o_visible,
    input wire t_coord                  o_clipped_start_x,
    input wire t_coord                  o_clipped_start_y,
    input wire t_coord                  o_clipped_end_x,
    input wire t_coord                  o_clipped_end_y
);

    a_ready_law: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat present right after reset");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_visible) |->
            (o_clipped_start_x == '0 && o_clipped_start_y == '0 &&
             o_clipped_end_x == '0 && o_clipped_end_y == '0))
        else $error("rejected beat carries nonzero coordinates");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_visible) && $stable(o_clipped_start_x) &&
             $stable(o_clipped_end_y)))
        else $error("stalled output beat changed");

endmodule

bind line_segment_window_clipper lsc_checker u_lsc_checker (.*);

`default_nettype wire

[tb/lsc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsc_scoreboard
// Watches the segment and result channels of the window clipper, computes
// the expected clip of every accepted segment and compares the results.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_scoreboard import lsc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire t_coord      i_start_x,
    input  wire t_coord      i_start_y,
    input  wire t_coord      i_end_x,
    input  wire t_coord      i_end_y,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_visible,
    input  wire t_coord      i_clipped_start_x,
    input  wire t_coord      i_clipped_start_y,
    input  wire t_coord      i_clipped_end_x,
    input  wire t_coord      i_clipped_end_y,
    input  wire logic        i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire t_coord      i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic   vis;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_clip;

    t_coord win_left, win_bottom, win_right, win_top;
    t_clip  clip_queue[$];

    assign o_pending = clip_queue.size();

    function automatic logic [3:0] region(longint px, longint py);
        logic [3:0] c;
        c = '0;
        if (px < longint'(win_left)) c |= OC_LEFT;
        else if (px > longint'(win_right)) c |= OC_RIGHT;
        if (py < longint'(win_bottom)) c |= OC_BELOW;
        else if (py > longint'(win_top)) c |= OC_ABOVE;
        return c;
    endfunction

    function automatic logic edge_test(longint delta, longint diff,
                                       inout longint t_in, inout longint t_out);
        longint ad, af, t;
        ad = delta < 0 ? -delta : delta;
        af = diff < 0 ? -diff : diff;
        if (af * 100000 < ad) return 1'b0;
        if ((delta < 0) != (diff < 0)) return delta < 0;
        t = (af << T_FRAC_BITS) / ad;
        if (delta < 0) begin
            if (t > t_out) return 1'b0;
            if (t > t_in) t_in = t;
        end else begin
            if (t < t_in) return 1'b0;
            if (t < t_out) t_out = t;
        end
        return 1'b1;
    endfunction

    function automatic t_coord move_along(longint base, longint t, longint d);
        longint r;
        r = (t * (d < 0 ? -d : d) + (longint'(1) << (T_FRAC_BITS - 1))) >> T_FRAC_BITS;
        return t_coord'(d < 0 ? base - r : base + r);
    endfunction

    function automatic t_clip clip_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        t_clip r;
        longint x1, y1, x2, y2, dx, dy, t_in, t_out;
        logic [3:0] c1, c2;
        logic ok;
        x1 = sx; y1 = sy; x2 = ex; y2 = ey;
        dx = x2 - x1; dy = y2 - y1;
        t_in = 0; t_out = longint'(1) << T_FRAC_BITS;
        r = '0;
        c1 = region(x1, y1);
        c2 = region(x2, y2);
        if ((c1 | c2) == 0) begin
            r.vis = 1'b1; r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
            return r;
        end
        if ((c1 & c2) != 0) return r;
        ok = (dx == 0) || edge_test(-dx, x1 - win_left, t_in, t_out);
        ok = ok && ((dy == 0) || edge_test(dy, win_top - y1, t_in, t_out));
        ok = ok && ((dx == 0) || edge_test(dx, win_right - x1, t_in, t_out));
        ok = ok && ((dy == 0) || edge_test(-dy, y1 - win_bottom, t_in, t_out));
        if (!ok) return r;
        r.vis = 1'b1;
        r.sx = move_along(x1, t_in, dx);
        r.sy = move_along(y1, t_in, dy);
        r.ex = move_along(x1, t_out, dx);
        r.ey = move_along(y1, t_out, dy);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_clip want, got;
        if (!i_rst_n) begin
            win_left <= '0;
            win_bottom <= '0;
            win_right <= t_coord'(524287);
            win_top <= t_coord'(524287);
            o_fail_count <= 0;
            clip_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                clip_queue.push_back(clip_segment(i_start_x, i_start_y, i_end_x, i_end_y));
            if (i_out_valid && i_out_ready) begin
                got = {i_visible, i_clipped_start_x, i_clipped_start_y,
                       i_clipped_end_x, i_clipped_end_y};
                if (clip_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = clip_queue.pop_front();
                    if (want != got) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p, actual %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LEFT: begin
                        win_left <= i_cfg_data;
                    end
                    REG_BOTTOM: begin
                        win_bottom <= i_cfg_data;
                    end
                    REG_RIGHT: begin
                        win_right <= i_cfg_data;
                    end
                    default: begin
                        win_top <= i_cfg_data;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives segments through the window clipper under several window settings
// and idle patterns; the checker compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import lsc_pkg::*;

    localparam int LATENCY = 21;
    localparam int LIMIT = 400000;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready;
    t_coord i_start_x, i_start_y, i_end_x, i_end_y;
    logic o_out_valid, i_out_ready, o_visible;
    t_coord o_clipped_start_x, o_clipped_start_y, o_clipped_end_x, o_clipped_end_y;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    t_coord i_cfg_data;
    int fail_count, pending, cycles;
    int send_idle, recv_stall;

    line_segment_window_clipper dut (.*);

    lsc_scoreboard checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready),
        .i_start_x, .i_start_y, .i_end_x, .i_end_y,
        .i_out_valid(o_out_valid), .i_out_ready, .i_visible(o_visible),
        .i_clipped_start_x(o_clipped_start_x), .i_clipped_start_y(o_clipped_start_y),
        .i_clipped_end_x(o_clipped_end_x), .i_clipped_end_y(o_clipped_end_y),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        i_out_ready <= ($urandom_range(99) >= recv_stall);
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_coord any_coord();
        return t_coord'($urandom);
    endfunction

    task automatic write_window(logic [CFG_IDX_BITS-1:0] idx, t_coord val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_window(int l, int b, int r, int t);
        write_window(REG_LEFT, t_coord'(l));
        write_window(REG_BOTTOM, t_coord'(b));
        write_window(REG_RIGHT, t_coord'(r));
        write_window(REG_TOP, t_coord'(t));
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_segment(int sx, int sy, int ex, int ey);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= t_coord'(sx); i_start_y <= t_coord'(sy);
        i_end_x <= t_coord'(ex); i_end_y <= t_coord'(ey);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // mostly points near the window, some anywhere
    task automatic send_random(int n, t_coord l, t_coord b, t_coord r, t_coord t);
        int lo_x, hi_x, lo_y, hi_y, span;
        t_coord p[4];
        lo_x = (l < r) ? int'(l) : int'(r);
        hi_x = (l < r) ? int'(r) : int'(l);
        lo_y = (b < t) ? int'(b) : int'(t);
        hi_y = (b < t) ? int'(t) : int'(b);
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < 4; j++) begin
                span = (j % 2 == 0) ? hi_x - lo_x : hi_y - lo_y;
                if ($urandom_range(9) < 2)
                    p[j] = any_coord();
                else if ($urandom_range(9) == 0)
                    p[j] = t_coord'((j % 2 == 0) ? ($urandom_range(1) ? l : r)
                                                 : ($urandom_range(1) ? b : t));
                else
                    p[j] = t_coord'(((j % 2 == 0) ? lo_x : lo_y) - span / 2
                                    + int'($urandom_range(2 * span + 1)));
            end
            if ($urandom_range(9) == 0) p[2] = p[0];
            if ($urandom_range(9) == 0) p[3] = p[1];
            if (k == n / 2 && n > 20) drain();
            send_segment(p[0], p[1], p[2], p[3]);
        end
    endtask

    initial begin
        t_coord mx, mn;
        mx = t_coord'(524287);
        mn = t_coord'(-524288);
        cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_start_x = '0; i_start_y = '0; i_end_x = '0; i_end_y = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        send_idle = 0; recv_stall = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default window, extremes
        send_segment(mn, mn, mx, mx);
        send_segment(mx, mx, mn, mn);
        send_segment(10, 10, 100, 200);
        send_segment(-5, -5, -100, 50);
        drain();
        set_window(-1600, -1600, 1600, 1600);
        send_segment(0, 0, 100, 100);
        send_segment(-3200, 0, 3200, 0);
        send_segment(0, -3200, 0, 3200);
        send_segment(-3200, -3200, 3200, 3200);
        send_segment(3200, 3200, -3200, 100);
        send_segment(-1600, 0, -3200, 0);
        send_segment(-1600, -1600, -1700, 1700);
        send_segment(-1601, 0, 1600, 0);
        send_segment(mn, 0, mx, 1);
        send_segment(mn, mn, mn, mx);
        send_segment(-2000, 2000, 2000, 2000);
        send_segment(-1700, 0, 0, 1700);
        send_segment(5000, 0, 0, 5000);
        send_segment(mx, 1, mn, 0);
        send_segment(-1601, 1601, 1601, -1601);
        drain();
        set_window(mn, mn, mx, mx);
        send_segment(mn, mx, mx, mn);
        send_segment(any_coord(), any_coord(), any_coord(), any_coord());
        drain();
        set_window(100, 100, -100, -100);
        send_segment(0, 0, 50, 50);
        send_segment(-200, 0, 200, 10);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            t_coord l, b, r, t;
            case (phase)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 65; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 65; end
                default: begin send_idle = 26; recv_stall = 26; end
            endcase
            l = t_coord'(int'($urandom_range(8000)) - 4000);
            b = t_coord'(int'($urandom_range(8000)) - 4000);
            r = l + t_coord'($urandom_range(6000, 1));
            t = b + t_coord'($urandom_range(6000, 1));
            if (phase == 3) begin
                r = l - t_coord'(40);
            end
            set_window(l, b, r, t);
            send_random(115, l, b, r, t);
            drain();
        end
        send_idle = 10; recv_stall = 10;
        set_window(mn, mn, mx, mx);
        send_random(40, mn, mn, mx, mx);
        drain();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
